@@ rtl/core/fcrla_pkg.sv @@
// Shared constants, types and widths for the four-channel rate-limited averager.
package fcrla_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int SAMPLE_BITS = 16;

	localparam int LANES    = 4;
	localparam int RAW_W    = 16;
	localparam int AVG_W    = 16;
	localparam int COUNT_W  = 13;
	localparam int TIME_W   = 32;
	localparam int IVAL_W   = 16;
	localparam int TALLY_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_SAMPLES);
	localparam int STEP_W   = $clog2(SUM_W);
	localparam int IN_W     = 104;
	localparam int OUT_W    = 80;

	localparam logic [IVAL_W-1:0] EMIT_INTERVAL_RESET = IVAL_W'(1000);

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_STOP   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic load;
		logic step;
	} lane_ctrl_t;

endpackage

@@ rtl/core/four_channel_rate_limited_averager_top.sv @@
// Top level: item decode, interval timer, four averaging lanes and the result register.
//
//  channel   direction  accept when            payload
//  s_*       in         s_tvalid & s_tready    tuser: func; tdata: link, time, four pads
//  m_*       out        m_tvalid & m_tready    tdata: four averages, samples averaged
//  cfg_*     in         cfg_we                 cfg_data: emit interval in microseconds
//
// A start, stop, ignored or non-emitting sample item is taken in the idle state, which stays ready.
// An emitting sample item then passes through the load, divide and done states:
// it loads the lanes, runs SUM_W steps of the shared-count serial dividers, then merges.
// The result register lets the next item in while a finished result waits; a further
// emitting item holds at the merge step until that register is free.
// Reset clears state at once; there is no clearing pass.
module four_channel_rate_limited_averager_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] link_up, [32:1] time_us, [48:33] face_left_raw, [64:49] rim_left_raw,
	// [80:65] face_right_raw, [96:81] rim_right_raw, rest zero
	input  logic [fcrla_pkg::IN_W-1:0]    s_tdata,
	// [1:0] func
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] face_left_avg, [31:16] rim_left_avg, [47:32] face_right_avg,
	// [63:48] rim_right_avg, [76:64] samples_averaged, rest zero
	output logic [fcrla_pkg::OUT_W-1:0]   m_tdata,
	input  logic                          cfg_we,
	input  logic [fcrla_pkg::IVAL_W-1:0]  cfg_data
);
	import fcrla_pkg::*;

	state_t             state_q, state_d;
	logic [IVAL_W-1:0]  ival_q;
	logic               stream_q;
	logic [TIME_W-1:0]  last_q;
	logic [TALLY_W-1:0] tally_q;
	logic [TALLY_W-1:0] tally_inc;
	logic [TALLY_W-1:0] div_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               out_valid_q;
	logic [AVG_W-1:0]   avg_q [LANES];
	logic [TALLY_W-1:0] count_q;

	func_t              func;
	logic               accept;
	logic               sample_ok;
	logic               room;
	logic               hit;
	logic [TIME_W-1:0]  elapsed;
	logic               emit;
	logic               out_load;
	lane_ctrl_t         lctrl;
	logic [SAMPLE_BITS-1:0] samp [LANES];
	logic [AVG_W-1:0]   avg [LANES];

	assign func      = func_t'(s_tuser);
	assign accept    = s_tvalid && s_tready;
	assign sample_ok = (func == FUNC_SAMPLE) && stream_q && s_tdata[0];
	assign room      = tally_q < TALLY_W'(MAX_SAMPLES);
	assign tally_inc = room ? tally_q + TALLY_W'(1) : tally_q;
	assign elapsed   = s_tdata[32:1] - last_q;
	assign hit       = elapsed >= TIME_W'(ival_q);
	assign emit      = accept && sample_ok && hit && (tally_inc != '0);

	assign samp[0] = s_tdata[33 +: SAMPLE_BITS];
	assign samp[1] = s_tdata[49 +: SAMPLE_BITS];
	assign samp[2] = s_tdata[65 +: SAMPLE_BITS];
	assign samp[3] = s_tdata[81 +: SAMPLE_BITS];

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			fcrla_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (lctrl),
				.sample  (samp[g]),
				.divisor (div_q),
				.avg     (avg[g])
			);
		end
	endgenerate

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		out_load    = 1'b0;
		lctrl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				lctrl.clear = accept && (func == FUNC_START);
				lctrl.add   = accept && sample_ok && room;
				if (emit) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				lctrl.load = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				lctrl.step = 1'b1;
				if (cnt_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ival_q <= EMIT_INTERVAL_RESET;
		end else if (cfg_we) begin
			ival_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q <= 1'b0;
			last_q   <= '0;
			tally_q  <= '0;
		end else if (state_q == ST_LOAD) begin
			tally_q <= '0;
		end else if (accept) begin
			unique case (func)
				FUNC_START: begin
					stream_q <= 1'b1;
					tally_q  <= '0;
				end
				FUNC_STOP: stream_q <= 1'b0;
				FUNC_SAMPLE: begin
					if (sample_ok) begin
						tally_q <= tally_inc;
						if (hit) begin
							last_q <= s_tdata[32:1];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			div_q <= tally_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + STEP_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Merge the lane means into the result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < LANES; i++) begin
				avg_q[i] <= avg[i];
			end
			count_q <= div_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, COUNT_W'(count_q), avg_q[3], avg_q[2], avg_q[1], avg_q[0]};

`ifndef ASSERT_OFF
	a_load_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> $past(s_tvalid && s_tready))
		else $error("lane load without an accepted item");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0))
		else $error("division started with a zero tally");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_W'(MAX_SAMPLES))
		else $error("sample tally above its limit");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[76:64] != '0))
		else $error("result carries a zero sample count");
`endif

endmodule

@@ rtl/core/fcrla_lane.sv @@
// One channel: running sum and a bit-serial restoring divider for its mean.
module fcrla_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fcrla_pkg::lane_ctrl_t            ctrl,
	input  logic [fcrla_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [fcrla_pkg::TALLY_W-1:0]     divisor,
	output logic [fcrla_pkg::AVG_W-1:0]       avg
);
	import fcrla_pkg::*;

	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   quo_q;
	logic [TALLY_W-1:0] rem_q;
	logic [TALLY_W:0]   trial;
	logic [TALLY_W:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear || ctrl.load) begin
			sum_q <= '0;
		end else if (ctrl.add) begin
			sum_q <= sum_q + SUM_W'(sample);
		end
	end

	// Dividend shifts out of the top while quotient bits fill in from the bottom.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= sum_q;
			rem_q <= '0;
		end else if (ctrl.step) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[TALLY_W-1:0] : trial[TALLY_W-1:0];
		end
	end

	// The mean never exceeds the largest sample value.
	assign avg = AVG_W'(quo_q[SAMPLE_BITS-1:0]);

endmodule

@@ tb/four_channel_rate_limited_averager_top_tb.sv @@
// Testbench for the four-channel rate-limited averager: directed and random item streams.
`timescale 1ns / 1ps

module four_channel_rate_limited_averager_top_tb;

	import fcrla_pkg::*;

	localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
	localparam logic [15:0] PAD_MASK      = 16'((32'd1 << SAMPLE_BITS) - 1);
	localparam int          SETTLE_CYCLES = 40;
	localparam int          MAX_REPORTS   = 10;
	localparam int          CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [1:0]  func;
		logic        link_up;
		logic [31:0] now_us;
		logic [15:0] face_left;
		logic [15:0] rim_left;
		logic [15:0] face_right;
		logic [15:0] rim_right;
	} pad_item_t;

	// Ordered to match m_tdata[76:0], highest field first.
	typedef struct packed {
		logic [12:0] count;
		logic [15:0] rim_right;
		logic [15:0] face_right;
		logic [15:0] rim_left;
		logic [15:0] face_left;
	} avg_set_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	// [0] link_up, [32:1] time_us, [48:33] face_left_raw, [64:49] rim_left_raw,
	// [80:65] face_right_raw, [96:81] rim_right_raw, rest zero
	logic [IN_W-1:0]  s_tdata;
	// [1:0] func
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	// [15:0] face_left_avg, [31:16] rim_left_avg, [47:32] face_right_avg,
	// [63:48] rim_right_avg, [76:64] samples_averaged, rest zero
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_we;
	logic [IVAL_W-1:0] cfg_data;

	// Predicted block state
	logic              acc_on;
	logic [31:0]       last_emit_us;
	logic [31:0]       acc_sum [LANES];
	logic [12:0]       acc_count;
	logic [IVAL_W-1:0] interval_us;

	avg_set_t    pending_avgs[$];
	avg_set_t    got_set;
	avg_set_t    want_set;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_max_gap = 10;
	int unsigned rx_max_gap = 10;
	int unsigned rx_hold_cycles = 0;
	logic [31:0] clock_us = '0;

	four_channel_rate_limited_averager_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic clear_sums();
		for (int i = 0; i < LANES; i++)
			acc_sum[i] = '0;
		acc_count = '0;
	endtask

	task automatic predict_averages(input pad_item_t it);
		logic [31:0] elapsed;
		logic [15:0] pads [LANES];
		logic [15:0] means [LANES];
		avg_set_t    set;
		pads[0] = it.face_left;
		pads[1] = it.rim_left;
		pads[2] = it.face_right;
		pads[3] = it.rim_right;
		case (it.func)
			FUNC_START: begin
				acc_on = 1'b1;
				clear_sums();
			end
			FUNC_STOP: acc_on = 1'b0;
			FUNC_SAMPLE: begin
				if (acc_on && it.link_up) begin
					// drop the sample once the tally is full, but still check the interval
					if (acc_count < MAX_SAMPLES) begin
						for (int i = 0; i < LANES; i++)
							acc_sum[i] = acc_sum[i] + 32'(pads[i] & PAD_MASK);
						acc_count = acc_count + 13'd1;
					end
					elapsed = it.now_us - last_emit_us;
					if (elapsed >= {16'd0, interval_us}) begin
						last_emit_us = it.now_us;
						if (acc_count != 0) begin
							for (int i = 0; i < LANES; i++)
								means[i] = 16'(acc_sum[i] / {19'd0, acc_count});
							set.face_left  = means[0];
							set.rim_left   = means[1];
							set.face_right = means[2];
							set.rim_right  = means[3];
							set.count      = acc_count;
							pending_avgs.push_back(set);
							clear_sums();
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic pad_item_t make_item(input logic [1:0] func, input logic link,
		input logic [31:0] now, input logic [15:0] fl, input logic [15:0] rl,
		input logic [15:0] fr, input logic [15:0] rr);
		pad_item_t it;
		it.func       = func;
		it.link_up    = link;
		it.now_us     = now;
		it.face_left  = fl;
		it.rim_left   = rl;
		it.face_right = fr;
		it.rim_right  = rr;
		return it;
	endfunction

	function automatic logic [15:0] rand_pad();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Favor start while streaming is off so most items reach the accumulators.
	function automatic pad_item_t random_item(input logic [15:0] ival);
		int unsigned pick;
		logic [1:0]  func;
		pick = $urandom_range(0, 99);
		if (!acc_on && pick < 30)
			func = FUNC_START;
		else if (pick < 2)
			func = FUNC_START;
		else if (pick < 5)
			func = FUNC_STOP;
		else if (pick < 7)
			func = FUNC_UNUSED;
		else
			func = FUNC_SAMPLE;
		if ($urandom_range(0, 49) == 0)
			clock_us = $urandom;
		else
			clock_us = clock_us + $urandom_range(0, 2 * ival);
		return make_item(func, $urandom_range(0, 9) != 0, clock_us,
			rand_pad(), rand_pad(), rand_pad(), rand_pad());
	endfunction

	task automatic send_item(input pad_item_t it);
		int unsigned gap;
		gap = $urandom_range(0, tx_max_gap);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {7'd0, it.rim_right, it.face_right, it.rim_left, it.face_left,
			it.now_us, it.link_up};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_averages(it);
	endtask

	// Let the block drain and settle before touching the register.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_avgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_interval(input logic [15:0] ival);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= ival;
		@(posedge clk);
		cfg_we <= 1'b0;
		interval_us = ival;
	endtask

	task automatic log_mismatch(input string what, input avg_set_t want, input avg_set_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected fl=%h rl=%h fr=%h rr=%h n=%0d, got fl=%h rl=%h fr=%h rr=%h n=%0d",
				$realtime, what, want.face_left, want.rim_left, want.face_right,
				want.rim_right, want.count, got.face_left, got.rim_left, got.face_right,
				got.rim_right, got.count);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_set = m_tdata[76:0];
			if (pending_avgs.size() == 0) begin
				log_mismatch("result with nothing expected", '0, got_set);
			end else begin
				want_set = pending_avgs.pop_front();
				if (got_set.face_left !== want_set.face_left ||
						got_set.rim_left !== want_set.rim_left ||
						got_set.face_right !== want_set.face_right ||
						got_set.rim_right !== want_set.rim_right ||
						got_set.count !== want_set.count)
					log_mismatch("average mismatch", want_set, got_set);
			end
		end
	end

	// Receiver: random stalls per transaction, plus one long hold when asked.
	initial begin : receiver
		int unsigned gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles != 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				gap = $urandom_range(0, rx_max_gap);
			end
			repeat (gap) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic test_commands_at_reset_interval();
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'd0, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
		send_item(make_item(FUNC_UNUSED, 1'b1, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(make_item(FUNC_STOP, 1'b0, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(make_item(FUNC_START, 1'b1, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b0, 32'd5000, 16'hFFFF, 16'h1, 16'h2, 16'h3));
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// one short of the interval, then exactly on it
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'd999, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'd1000, 16'h1, 16'h2, 16'hFFFF, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'd1500, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h1));
		send_item(make_item(FUNC_STOP, 1'b1, 32'd1600, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'd3000, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_item(make_item(FUNC_START, 1'b1, 32'd3000, 16'h0, 16'h0, 16'h0, 16'h0));
		// time wraps: the difference is taken modulo 2^32
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'hFFFF_FFF0, 16'h1234, 16'hABCD, 16'hFFFF, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'h0000_0010, 16'h4321, 16'h0001, 16'h0, 16'hFFFF));
		send_item(make_item(FUNC_SAMPLE, 1'b1, 32'h0000_03D8, 16'h0003, 16'h0, 16'hFFFE, 16'h8000));
		send_item(make_item(FUNC_UNUSED, 1'b0, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(make_item(FUNC_STOP, 1'b1, 32'h0000_03D8, 16'h0, 16'h0, 16'h0, 16'h0));
		clock_us = 32'h0000_03D8;
	endtask

	task automatic test_interval_extremes();
		// zero interval: every sample taken while streaming with the link up emits
		write_interval(16'd0);
		send_item(make_item(FUNC_START, 1'b1, clock_us, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0));
		send_item(make_item(FUNC_SAMPLE, 1'b0, clock_us, 16'h1, 16'h1, 16'h1, 16'h1));
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF));
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us - 32'd1, 16'h7, 16'h8, 16'h9, 16'hA));
		write_interval(16'd1);
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us - 32'd1, 16'h3, 16'h4, 16'h5, 16'h6));
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us, 16'h4, 16'h5, 16'h6, 16'h8));
		write_interval(16'hFFFF);
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us + 32'd65534, 16'hFFFF, 16'h1, 16'h2, 16'h3));
		send_item(make_item(FUNC_SAMPLE, 1'b1, clock_us + 32'd65535, 16'hFFFE, 16'h2, 16'h3, 16'h4));
		clock_us = clock_us + 32'd65535;
	endtask

	task automatic test_tally_limit();
		logic [31:0] base;
		tx_max_gap = 0;
		base = last_emit_us;
		send_item(make_item(FUNC_START, 1'b1, base, 16'h0, 16'h0, 16'h0, 16'h0));
		// overfill the tally; samples past the limit must be dropped
		repeat (MAX_SAMPLES + 4)
			send_item(make_item(FUNC_SAMPLE, 1'b1, base + 32'd1, 16'hFFFF, rand_pad(),
				rand_pad(), 16'($urandom)));
		send_item(make_item(FUNC_SAMPLE, 1'b1, base + 32'd65535, 16'h0, 16'h0, 16'h0, 16'h0));
		clock_us = base + 32'd65535;
		tx_max_gap = 10;
	endtask

	task automatic run_random_phase(input logic [15:0] ival, input int unsigned n_items,
		input int unsigned tx_gap, input int unsigned rx_gap, input int unsigned hold);
		write_interval(ival);
		tx_max_gap     = tx_gap;
		rx_max_gap     = rx_gap;
		rx_hold_cycles = hold;
		repeat (n_items)
			send_item(random_item(ival));
	endtask

	task automatic test_random_streams();
		run_random_phase(16'($urandom_range(1, 64)), 180, 10, 10, 0);
		// hold the receiver while items keep coming so the input backs up
		run_random_phase(16'd1, 150, 0, 0, 500);
		run_random_phase(16'hFFFF, 120, 10, 10, 0);
		run_random_phase(16'($urandom_range(1, 65535)), 150, 10, 10, 0);
		run_random_phase(16'($urandom_range(1, 300)), 150, 3, 10, 0);
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		arst_n   <= 1'b0;
		acc_on       = 1'b0;
		last_emit_us = '0;
		interval_us  = EMIT_INTERVAL_RESET;
		clear_sums();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands_at_reset_interval();
		test_interval_extremes();
		test_tally_limit();
		test_random_streams();

		drain();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
